// ===== rtl/core/icss_pkg.sv =====
package icss_pkg;

  // Request function codes
  typedef enum logic [2:0] {
    FUNC_TICK      = 3'd0,
    FUNC_START_ALL = 3'd1,
    FUNC_START_ONE = 3'd2,
    FUNC_GRANT     = 3'd3,
    FUNC_READ      = 3'd4
  } func_e;

  // Response status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SHOW   = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  // Configuration register indexes
  localparam int CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DWELL = 2'd0,
    CFG_CUES  = 2'd1
  } cfg_idx_e;

  localparam int DwellW = 16;
  localparam int CueW   = 5;
  localparam int MapW   = 16;

  localparam logic [DwellW-1:0] DwellReset = 16'd100;
  localparam logic [CueW-1:0]   CuesReset  = 5'd16;

  typedef struct packed {
    logic [DwellW-1:0] dwell_ticks;
    logic [CueW-1:0]   usable_cues;
  } cfg_t;

  typedef struct packed {
    logic [2:0]      func;
    logic [CueW-1:0] cue;
    logic            pin_level;
    logic            show_running;
  } req_t;

  typedef struct packed {
    logic [CueW-1:0] drive_cue;
    logic            test_window;
    logic            busy_res;
    logic            accepted;
    logic [1:0]      status_code;
    logic            cue_result;
    logic [MapW-1:0] result_map;
  } rsp_t;

endpackage

// ===== rtl/core/igniter_continuity_scan_sequencer_core.sv =====
// A response is registered in the cycle its request is accepted and is valid from the next cycle.
// Throughput: one request per cycle; the output register takes a new response
// in the cycle the held one is taken, so requests stall only on output back-pressure.
// Reset (async, active low): idle, not authorised, all cue results clear,
// dwell_ticks = 100, usable_cues = 16.
module igniter_continuity_scan_sequencer_core #(
  parameter int MAX_CUES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [icss_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [icss_pkg::DwellW-1:0]   cfg_data_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    func_i,
  input  logic [icss_pkg::CueW-1:0]     cue_i,
  input  logic                          pin_level_i,
  input  logic                          show_running_i,
  // response channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [icss_pkg::CueW-1:0]     drive_cue_o,
  output logic                          test_window_o,
  output logic                          busy_res_o,
  output logic                          accepted_o,
  output logic [1:0]                    status_code_o,
  output logic                          cue_result_o,
  output logic [icss_pkg::MapW-1:0]     result_map_o
);

  icss_pkg::cfg_t cfg;
  icss_pkg::req_t req;
  icss_pkg::rsp_t rsp;
  icss_pkg::rsp_t rsp_q;
  logic           req_fire;

  assign req.func         = func_i;
  assign req.cue          = cue_i;
  assign req.pin_level    = pin_level_i;
  assign req.show_running = show_running_i;
  assign req_fire         = in_valid_i && in_ready_o;

  // Configuration registers
  icss_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Sequencer state and per-request logic
  icss_seq #(
    .MAX_CUES (MAX_CUES)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_fire_i (req_fire),
    .req_i      (req),
    .cfg_i      (cfg),
    .rsp_o      (rsp)
  );

  // Response register
  icss_oreg u_oreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (rsp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (rsp_q)
  );

  assign drive_cue_o   = rsp_q.drive_cue;
  assign test_window_o = rsp_q.test_window;
  assign busy_res_o    = rsp_q.busy_res;
  assign accepted_o    = rsp_q.accepted;
  assign status_code_o = rsp_q.status_code;
  assign cue_result_o  = rsp_q.cue_result;
  assign result_map_o  = rsp_q.result_map;

endmodule

// ===== rtl/core/icss_cfg.sv =====
module icss_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [icss_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [icss_pkg::DwellW-1:0]   cfg_data_i,
  output icss_pkg::cfg_t                cfg_o
);

  icss_pkg::cfg_t cfg_q, cfg_d;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (icss_pkg::cfg_idx_e'(cfg_index_i))
        icss_pkg::CFG_DWELL: cfg_d.dwell_ticks = cfg_data_i;
        icss_pkg::CFG_CUES:  cfg_d.usable_cues = cfg_data_i[icss_pkg::CueW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dwell_ticks <= icss_pkg::DwellReset;
      cfg_q.usable_cues <= icss_pkg::CuesReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/icss_seq.sv =====
module icss_seq #(
  parameter int MAX_CUES = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_fire_i,
  input  icss_pkg::req_t  req_i,
  input  icss_pkg::cfg_t  cfg_i,
  output icss_pkg::rsp_t  rsp_o
);

  localparam int CueW = icss_pkg::CueW;
  localparam int MapN = (MAX_CUES < icss_pkg::MapW) ? MAX_CUES : icss_pkg::MapW;

  logic                       running_q, running_d;
  logic                       scan_all_q, scan_all_d;
  logic                       auth_q, auth_d;
  logic [CueW-1:0]            idx_q, idx_d;
  logic [icss_pkg::DwellW-1:0] dwell_q, dwell_d;
  logic [MAX_CUES-1:0]        res_q, res_d;

  logic [CueW-1:0]            eff_cues;
  logic                       cue_ok;
  logic [CueW-1:0]            cue_idx;
  logic                       accepted;
  icss_pkg::status_e          status;
  logic                       cue_res;

  // Effective cue count, clamped to 1..MAX_CUES
  always_comb begin
    if (cfg_i.usable_cues == '0) begin
      eff_cues = CueW'(1);
    end else if (32'(cfg_i.usable_cues) > MAX_CUES) begin
      eff_cues = CueW'(MAX_CUES);
    end else begin
      eff_cues = cfg_i.usable_cues;
    end
  end

  assign cue_ok  = (req_i.cue != '0) && (req_i.cue <= eff_cues);
  assign cue_idx = req_i.cue - CueW'(1);

  // Next state and response for one request
  always_comb begin
    running_d  = running_q;
    scan_all_d = scan_all_q;
    auth_d     = auth_q;
    idx_d      = idx_q;
    dwell_d    = dwell_q;
    res_d      = res_q;
    accepted   = 1'b0;
    status     = icss_pkg::ST_OK;
    cue_res    = 1'b0;

    case (icss_pkg::func_e'(req_i.func))
      icss_pkg::FUNC_TICK: begin
        if (running_q) begin
          if (dwell_q >= cfg_i.dwell_ticks) begin
            // sample return pin into the cue under test
            for (int i = 0; i < MAX_CUES; i++) begin
              if (32'(idx_q) == i) res_d[i] = req_i.pin_level;
            end
            dwell_d = '0;
            if (scan_all_q && ({1'b0, idx_q} + 6'd1 < {1'b0, eff_cues})) begin
              idx_d = idx_q + CueW'(1);
            end else begin
              running_d = 1'b0;
            end
          end else begin
            dwell_d = dwell_q + 16'd1;
          end
        end
      end
      icss_pkg::FUNC_START_ALL: begin
        if (req_i.show_running) begin
          status = icss_pkg::ST_SHOW;
        end else if (running_q || !auth_q) begin
          status = icss_pkg::ST_REJECT;
        end else begin
          running_d  = 1'b1;
          scan_all_d = 1'b1;
          idx_d      = '0;
          dwell_d    = '0;
          auth_d     = 1'b0;
          accepted   = 1'b1;
        end
      end
      icss_pkg::FUNC_START_ONE: begin
        if (running_q || !auth_q || !cue_ok) begin
          status = icss_pkg::ST_REJECT;
        end else begin
          running_d  = 1'b1;
          scan_all_d = 1'b0;
          idx_d      = cue_idx;
          dwell_d    = '0;
          auth_d     = 1'b0;
          accepted   = 1'b1;
        end
      end
      icss_pkg::FUNC_GRANT: begin
        auth_d = 1'b1;
      end
      icss_pkg::FUNC_READ: begin
        if (cue_ok) begin
          for (int i = 0; i < MAX_CUES; i++) begin
            if (32'(cue_idx) == i) cue_res = res_q[i];
          end
        end else begin
          status = icss_pkg::ST_REJECT;
        end
      end
      default: begin
        status = icss_pkg::ST_REJECT;
      end
    endcase
  end

  // Response, taken from the state after the request
  always_comb begin
    rsp_o             = '0;
    rsp_o.drive_cue   = running_d ? (idx_d + CueW'(1)) : '0;
    rsp_o.test_window = running_d;
    rsp_o.busy_res    = running_d;
    rsp_o.accepted    = accepted;
    rsp_o.status_code = status;
    rsp_o.cue_result  = cue_res;
    rsp_o.result_map  = icss_pkg::MapW'(res_d[MapN-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q  <= 1'b0;
      scan_all_q <= 1'b0;
      auth_q     <= 1'b0;
      idx_q      <= '0;
      dwell_q    <= '0;
      res_q      <= '0;
    end else if (req_fire_i) begin
      running_q  <= running_d;
      scan_all_q <= scan_all_d;
      auth_q     <= auth_d;
      idx_q      <= idx_d;
      dwell_q    <= dwell_d;
      res_q      <= res_d;
    end
  end

endmodule

// ===== rtl/core/icss_oreg.sv =====
module icss_oreg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  icss_pkg::rsp_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output icss_pkg::rsp_t  out_data_o
);

  logic           valid_q, valid_d;
  icss_pkg::rsp_t data_q;

  // Free when empty or when the held response leaves this cycle
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) valid_d = in_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) data_q <= in_data_i;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
